// ===== rtl/core/ecc_pkg.sv =====
package ecc_pkg;

	localparam int FRAC_BITS_DEF = 4;

	localparam int POS_W  = 16;
	localparam int VEL_W  = 16;
	localparam int RADI_W = 11;
	localparam int MASS_W = 8;

	// internal widths, bounded by what a colliding pair can produce
	localparam int DIF_W  = POS_W + 1;             // centre and velocity differences
	localparam int SUM_W  = RADI_W + 1;            // ra + rb
	localparam int SQ_W   = 2 * DIF_W;             // squares and dot terms
	localparam int ACC_W  = SQ_W + 1;              // d2 and rel
	localparam int D2H_W  = 2 * SUM_W;             // d2 below (ra + rb)^2
	localparam int MAG_W  = SUM_W;                 // |d_axis| below ra + rb
	localparam int APP_W  = 29;                    // -rel on a hit
	localparam int MSUM_W = MASS_W + 1;
	localparam int VNUM_W = APP_W + MAG_W;         // q * |d_axis|
	localparam int VDEN_W = MSUM_W + D2H_W;        // M * d2
	localparam int VN_W   = VNUM_W + MASS_W + 3;   // rounded velocity numerator
	localparam int VD_W   = VDEN_W + 1;
	localparam int VQ_W   = 18;                    // velocity change magnitude
	localparam int PQ_W   = 12;                    // push magnitude

	typedef struct packed {
		logic        [POS_W-1:0]  a_pos_x;
		logic        [POS_W-1:0]  a_pos_y;
		logic        [POS_W-1:0]  b_pos_x;
		logic        [POS_W-1:0]  b_pos_y;
		logic signed [VEL_W-1:0]  a_vel_x;
		logic signed [VEL_W-1:0]  a_vel_y;
		logic signed [VEL_W-1:0]  b_vel_x;
		logic signed [VEL_W-1:0]  b_vel_y;
		logic        [RADI_W-1:0] a_radius;
		logic        [RADI_W-1:0] b_radius;
		logic        [MASS_W-1:0] a_mass;
		logic        [MASS_W-1:0] b_mass;
	} ecc_in_t;

	typedef struct packed {
		logic        [POS_W-1:0] new_a_pos_x;
		logic        [POS_W-1:0] new_a_pos_y;
		logic        [POS_W-1:0] new_b_pos_x;
		logic        [POS_W-1:0] new_b_pos_y;
		logic signed [VEL_W-1:0] new_a_vel_x;
		logic signed [VEL_W-1:0] new_a_vel_y;
		logic signed [VEL_W-1:0] new_b_vel_x;
		logic signed [VEL_W-1:0] new_b_vel_y;
		logic                    collided;
	} ecc_out_t;

	function automatic logic [POS_W-1:0] sat_u16(input logic signed [POS_W+1:0] v);
		logic [POS_W-1:0] r;
		if (v[POS_W+1])
			r = '0;
		else if (v[POS_W])
			r = '1;
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

	function automatic logic [VEL_W-1:0] sat_s16(input logic signed [VEL_W+3:0] v);
		logic [VEL_W-1:0] r;
		if ((v[VEL_W+3:VEL_W-1] == '0) || (v[VEL_W+3:VEL_W-1] == '1))
			r = v[VEL_W-1:0];
		else if (v[VEL_W+3])
			r = {1'b1, {(VEL_W-1){1'b0}}};
		else
			r = {1'b0, {(VEL_W-1){1'b1}}};
		return r;
	endfunction

endpackage

// ===== rtl/core/elastic_circle_pair_collision.sv =====
// Resolves one circle pair per word: overlap and approach test, half-overlap push
// of both centres along the normal, elastic exchange of the normal velocities,
// saturated results. One pair is accepted every cycle while pair_stall is low; the depth
// of the pipe is set by the square root of the centre distance (one root bit per
// stage, 12 + 2*FRAC_BITS stages) followed by the push divider (one quotient bit per
// stage, 12 stages). The velocity dividers run in parallel and are delay matched.
// pair_stall rises only when a result is held on result_stall and the skid word
// behind it is full; the whole pipe then freezes in place.
module elastic_circle_pair_collision #(
	parameter int FRAC_BITS = ecc_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pair_valid,
	output logic             pair_stall,
	input  ecc_pkg::ecc_in_t pair_word,
	output logic             result_valid,
	input  logic             result_stall,
	output ecc_pkg::ecc_out_t result_word
);
	import ecc_pkg::*;

	localparam int G        = 2 * FRAC_BITS;
	localparam int RAD_W    = D2H_W + 2 * G;
	localparam int ROOT_W   = RAD_W / 2;
	localparam int PN_W     = MAG_W + ROOT_W + 2;
	localparam int PD_W     = ROOT_W + 2;
	localparam int PUSH_LAT = ROOT_W + 1 + PQ_W;
	localparam int VEL_LAT  = 2 + VQ_W;
	localparam int VDLY     = PUSH_LAT - VEL_LAT;
	localparam int GEO_W    = SUM_W + 2 * MAG_W;
	localparam int SIDE_W   = $bits(ecc_in_t) + 3;

	logic en;
	logic out_valid_q, skid_valid_q;
	ecc_out_t out_q, skid_q;

	assign en         = !skid_valid_q;
	assign pair_stall = skid_valid_q;

	// stage 1: differences
	logic                    v_s1;
	ecc_in_t                 in_s1;
	logic signed [DIF_W-1:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [SUM_W-1:0]        sum_s1;
	logic [MASS_W-1:0]       ma_s1, mb_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1  <= pair_word;
			dx_s1  <= $signed({1'b0, pair_word.a_pos_x}) - $signed({1'b0, pair_word.b_pos_x});
			dy_s1  <= $signed({1'b0, pair_word.a_pos_y}) - $signed({1'b0, pair_word.b_pos_y});
			dvx_s1 <= $signed({pair_word.a_vel_x[VEL_W-1], pair_word.a_vel_x})
			        - $signed({pair_word.b_vel_x[VEL_W-1], pair_word.b_vel_x});
			dvy_s1 <= $signed({pair_word.a_vel_y[VEL_W-1], pair_word.a_vel_y})
			        - $signed({pair_word.b_vel_y[VEL_W-1], pair_word.b_vel_y});
			sum_s1 <= SUM_W'(pair_word.a_radius) + SUM_W'(pair_word.b_radius);
			// zero mass counts as one
			ma_s1  <= (pair_word.a_mass == '0) ? MASS_W'(1) : pair_word.a_mass;
			mb_s1  <= (pair_word.b_mass == '0) ? MASS_W'(1) : pair_word.b_mass;
		end
	end

	// stage 2: squares and dot terms
	ecc_in_t                in_s2;
	logic [SQ_W-1:0]        dxx_s2, dyy_s2;
	logic signed [SQ_W-1:0] rx_s2, ry_s2;
	logic [D2H_W-1:0]       ss_s2;
	logic [MAG_W-1:0]       adx_s2, ady_s2;
	logic                   sgx_s2, sgy_s2;
	logic [SUM_W-1:0]       sum_s2;
	logic [MASS_W-1:0]      ma_s2, mb_s2;
	logic                   v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			in_s2  <= in_s1;
			dxx_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
			dyy_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
			rx_s2  <= SQ_W'(dvx_s1) * SQ_W'(dx_s1);
			ry_s2  <= SQ_W'(dvy_s1) * SQ_W'(dy_s1);
			ss_s2  <= D2H_W'(sum_s1) * D2H_W'(sum_s1);
			adx_s2 <= dx_s1[DIF_W-1] ? MAG_W'(-dx_s1) : MAG_W'(dx_s1);
			ady_s2 <= dy_s1[DIF_W-1] ? MAG_W'(-dy_s1) : MAG_W'(dy_s1);
			sgx_s2 <= dx_s1[DIF_W-1];
			sgy_s2 <= dy_s1[DIF_W-1];
			sum_s2 <= sum_s1;
			ma_s2  <= ma_s1;
			mb_s2  <= mb_s1;
		end
	end

	// stage 3: distance, approach, hit
	logic [ACC_W-1:0]        d2_c;
	logic signed [ACC_W-1:0] rel_c;
	logic                    hit_c;

	always_comb begin
		d2_c  = ACC_W'(dxx_s2) + ACC_W'(dyy_s2);
		rel_c = ACC_W'(rx_s2) + ACC_W'(ry_s2);
		hit_c = (d2_c != '0) && (d2_c < ACC_W'(ss_s2)) && rel_c[ACC_W-1];
	end

	ecc_in_t           in_s3;
	logic [D2H_W-1:0]  d2_s3;
	logic [APP_W-1:0]  q_s3;
	logic [MAG_W-1:0]  adx_s3, ady_s3;
	logic              hit_s3, sgx_s3, sgy_s3;
	logic [SUM_W-1:0]  sum_s3;
	logic [MSUM_W-1:0] msum_s3;
	logic [MASS_W-1:0] ma_s3, mb_s3;
	logic              v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			in_s3   <= in_s2;
			d2_s3   <= d2_c[D2H_W-1:0];
			q_s3    <= APP_W'(-rel_c);
			adx_s3  <= adx_s2;
			ady_s3  <= ady_s2;
			hit_s3  <= hit_c;
			sgx_s3  <= sgx_s2;
			sgy_s3  <= sgy_s2;
			sum_s3  <= sum_s2;
			msum_s3 <= MSUM_W'(ma_s2) + MSUM_W'(mb_s2);
			ma_s3   <= ma_s2;
			mb_s3   <= mb_s2;
		end
	end

	// velocity path
	logic [VNUM_W-1:0] nx_s4, ny_s4;
	logic [VDEN_W-1:0] den_s4;
	logic [MASS_W-1:0] ma_s4, mb_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s4  <= VNUM_W'(q_s3) * VNUM_W'(adx_s3);
			ny_s4  <= VNUM_W'(q_s3) * VNUM_W'(ady_s3);
			den_s4 <= VDEN_W'(msum_s3) * VDEN_W'(d2_s3);
			ma_s4  <= ma_s3;
			mb_s4  <= mb_s3;
		end
	end

	// numerators carry the rounding term: 2*(2*m*N) + den over 2*den
	logic [VN_W-1:0] vnax_s5, vnay_s5, vnbx_s5, vnby_s5;
	logic [VD_W-1:0] vd_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			vnax_s5 <= ((VN_W'(mb_s4) * VN_W'(nx_s4)) << 2) + VN_W'(den_s4);
			vnay_s5 <= ((VN_W'(mb_s4) * VN_W'(ny_s4)) << 2) + VN_W'(den_s4);
			vnbx_s5 <= ((VN_W'(ma_s4) * VN_W'(nx_s4)) << 2) + VN_W'(den_s4);
			vnby_s5 <= ((VN_W'(ma_s4) * VN_W'(ny_s4)) << 2) + VN_W'(den_s4);
			vd_s5   <= {den_s4, 1'b0};
		end
	end

	logic [VQ_W-1:0]   vqax, vqay, vqbx, vqby;
	logic [VQ_W-1:0]   vax_d, vay_d, vbx_d, vby_d;

	ecc_div #(.N_W(VN_W), .D_W(VD_W), .Q_W(VQ_W)) u_div_vax (
		.clk(clk), .en(en), .num(vnax_s5), .den(vd_s5), .quo(vqax));
	ecc_div #(.N_W(VN_W), .D_W(VD_W), .Q_W(VQ_W)) u_div_vay (
		.clk(clk), .en(en), .num(vnay_s5), .den(vd_s5), .quo(vqay));
	ecc_div #(.N_W(VN_W), .D_W(VD_W), .Q_W(VQ_W)) u_div_vbx (
		.clk(clk), .en(en), .num(vnbx_s5), .den(vd_s5), .quo(vqbx));
	ecc_div #(.N_W(VN_W), .D_W(VD_W), .Q_W(VQ_W)) u_div_vby (
		.clk(clk), .en(en), .num(vnby_s5), .den(vd_s5), .quo(vqby));

	ecc_delay #(.W(4 * VQ_W), .N(VDLY)) u_dly_vel (
		.clk(clk), .en(en),
		.din({vqax, vqay, vqbx, vqby}),
		.dout({vax_d, vay_d, vbx_d, vby_d}));

	// push path
	logic [ROOT_W-1:0] cdist;
	logic [SUM_W-1:0]  sum_d;
	logic [MAG_W-1:0]  adx_d, ady_d;

	ecc_sqrt #(.RAD_W(RAD_W), .ROOT_W(ROOT_W)) u_sqrt (
		.clk(clk), .en(en), .rad(RAD_W'(d2_s3) << (2 * G)), .root(cdist));

	ecc_delay #(.W(GEO_W), .N(ROOT_W)) u_dly_geo (
		.clk(clk), .en(en),
		.din({sum_s3, adx_s3, ady_s3}),
		.dout({sum_d, adx_d, ady_d}));

	logic [ROOT_W-1:0] over_c;
	logic [PN_W-1:0]   pnx_sp, pny_sp;
	logic [PD_W-1:0]   pd_sp;

	assign over_c = (ROOT_W'(sum_d) << G) - cdist;

	always_ff @(posedge clk) begin
		if (en) begin
			pnx_sp <= ((PN_W'(adx_d) * PN_W'(over_c)) << 1) + (PN_W'(cdist) << 1);
			pny_sp <= ((PN_W'(ady_d) * PN_W'(over_c)) << 1) + (PN_W'(cdist) << 1);
			pd_sp  <= PD_W'(cdist) << 2;
		end
	end

	logic [PQ_W-1:0] sx, sy;

	ecc_div #(.N_W(PN_W), .D_W(PD_W), .Q_W(PQ_W)) u_div_px (
		.clk(clk), .en(en), .num(pnx_sp), .den(pd_sp), .quo(sx));
	ecc_div #(.N_W(PN_W), .D_W(PD_W), .Q_W(PQ_W)) u_div_py (
		.clk(clk), .en(en), .num(pny_sp), .den(pd_sp), .quo(sy));

	// word and flags ride alongside
	ecc_in_t in_d;
	logic    hit_d, sgx_d, sgy_d;

	ecc_delay #(.W(SIDE_W), .N(PUSH_LAT)) u_dly_side (
		.clk(clk), .en(en),
		.din({in_s3, hit_s3, sgx_s3, sgy_s3}),
		.dout({in_d, hit_d, sgx_d, sgy_d}));

	// final: apply and saturate
	logic signed [POS_W+1:0] psx, psy, nax, nay, nbx, nby;
	logic signed [VEL_W+3:0] vxa, vya, vxb, vyb, navx, navy, nbvx, nbvy;
	ecc_out_t res_c, res_sf;
	logic     v_sf;

	always_comb begin
		psx  = sgx_d ? -(POS_W+2)'(sx) : (POS_W+2)'(sx);
		psy  = sgy_d ? -(POS_W+2)'(sy) : (POS_W+2)'(sy);
		nax  = $signed({2'b00, in_d.a_pos_x}) + psx;
		nay  = $signed({2'b00, in_d.a_pos_y}) + psy;
		nbx  = $signed({2'b00, in_d.b_pos_x}) - psx;
		nby  = $signed({2'b00, in_d.b_pos_y}) - psy;
		vxa  = sgx_d ? -(VEL_W+4)'(vax_d) : (VEL_W+4)'(vax_d);
		vya  = sgy_d ? -(VEL_W+4)'(vay_d) : (VEL_W+4)'(vay_d);
		vxb  = sgx_d ? -(VEL_W+4)'(vbx_d) : (VEL_W+4)'(vbx_d);
		vyb  = sgy_d ? -(VEL_W+4)'(vby_d) : (VEL_W+4)'(vby_d);
		navx = (VEL_W+4)'(in_d.a_vel_x) + vxa;
		navy = (VEL_W+4)'(in_d.a_vel_y) + vya;
		nbvx = (VEL_W+4)'(in_d.b_vel_x) - vxb;
		nbvy = (VEL_W+4)'(in_d.b_vel_y) - vyb;

		res_c.new_a_pos_x = hit_d ? sat_u16(nax)  : in_d.a_pos_x;
		res_c.new_a_pos_y = hit_d ? sat_u16(nay)  : in_d.a_pos_y;
		res_c.new_b_pos_x = hit_d ? sat_u16(nbx)  : in_d.b_pos_x;
		res_c.new_b_pos_y = hit_d ? sat_u16(nby)  : in_d.b_pos_y;
		res_c.new_a_vel_x = hit_d ? sat_s16(navx) : in_d.a_vel_x;
		res_c.new_a_vel_y = hit_d ? sat_s16(navy) : in_d.a_vel_y;
		res_c.new_b_vel_x = hit_d ? sat_s16(nbvx) : in_d.b_vel_x;
		res_c.new_b_vel_y = hit_d ? sat_s16(nbvy) : in_d.b_vel_y;
		res_c.collided    = hit_d;
	end

	always_ff @(posedge clk) begin
		if (en)
			res_sf <= res_c;
	end

	// valid bits
	logic [PUSH_LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			vld_q <= '0;
			v_sf  <= 1'b0;
		end else if (en) begin
			v_s1  <= pair_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			vld_q <= {vld_q[PUSH_LAT-2:0], v_s3};
			v_sf  <= vld_q[PUSH_LAT-1];
		end
	end

	// output word plus skid word
	logic take;
	assign take = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (en && v_sf) begin
			out_valid_q <= 1'b1;
			if (out_valid_q && !take)
				skid_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q  <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_sf) begin
			if (!out_valid_q || take)
				out_q <= res_sf;
			else
				skid_q <= res_sf;
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result_word  = out_q;
endmodule

// ===== rtl/core/ecc_delay.sv =====
module ecc_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] dly_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= din;
			for (int k = 1; k < N; k++)
				dly_s[k] <= dly_s[k-1];
		end
	end

	assign dout = dly_s[N-1];
endmodule

// ===== rtl/core/ecc_sqrt.sv =====
// floor square root, one root bit per stage
module ecc_sqrt #(
	parameter int RAD_W  = 40,
	parameter int ROOT_W = RAD_W / 2
) (
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);
	localparam int REM_W = ROOT_W + 2;

	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W-1];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [REM_W-1:0]  rem_in, cur, trial;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
		end

		// remainder stays below 2^ROOT_W going in, top two bits are free
		assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
		assign trial = {root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					rem_s[k]  <= cur - trial;
					root_s[k] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= cur;
					root_s[k] <= {root_in[ROOT_W-2:0], 1'b0};
				end
			end
		end

		if (k < ROOT_W - 1) begin : g_rad
			always_ff @(posedge clk) begin
				if (en)
					rad_s[k] <= rad_in << 2;
			end
		end
	end

	assign root = root_s[ROOT_W-1];
endmodule

// ===== rtl/core/ecc_div.sv =====
// restoring divider, one quotient bit per stage, MSB first
// quotient must fit in Q_W bits
module ecc_div #(
	parameter int N_W = 32,
	parameter int D_W = 16,
	parameter int Q_W = 16
) (
	input  logic           clk,
	input  logic           en,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic [Q_W-1:0] quo
);
	logic [N_W-1:0] rem_s [Q_W];
	logic [Q_W-1:0] quo_s [Q_W];
	logic [D_W-1:0] den_s [Q_W-1];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [N_W-1:0] rem_in, dsh;
		logic [Q_W-1:0] quo_in;
		logic [D_W-1:0] den_in;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
		end

		assign dsh = N_W'(den_in) << (Q_W - 1 - k);

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= dsh) begin
					rem_s[k] <= rem_in - dsh;
					quo_s[k] <= {quo_in[Q_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= rem_in;
					quo_s[k] <= {quo_in[Q_W-2:0], 1'b0};
				end
			end
		end

		if (k < Q_W - 1) begin : g_den
			always_ff @(posedge clk) begin
				if (en)
					den_s[k] <= den_in;
			end
		end
	end

	assign quo = quo_s[Q_W-1];
endmodule

// ===== rtl/core/ecc_checker.sv =====
module ecc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pair_valid,
	input logic              pair_stall,
	input logic              result_valid,
	input logic              result_stall,
	input ecc_pkg::ecc_out_t result_word
);
	import ecc_pkg::*;

	logic in_take;
	assign in_take = pair_valid && !pair_stall;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result_word))
		else $error("result word changed while stalled");

	a_res_stay: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result valid dropped while stalled");

	// skid word only exists behind a held output word
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> result_valid)
		else $error("input stalled with no result pending");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pair_stall) |-> $past(result_valid && result_stall) && !in_take)
		else $error("skid filled without an output stall");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall && !result_stall |=> !pair_stall)
		else $error("skid word not drained after output taken");
endmodule

bind elastic_circle_pair_collision ecc_checker u_ecc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pair_valid(pair_valid),
	.pair_stall(pair_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result_word(result_word)
);
